@@ rtl/mcsc_pkg.sv @@
// Package for the multi-cell sprite composer.
// Holds controller states, command/status structs, register indexes and field widths.
// No dependencies.
`default_nettype none

package mcsc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_CAMERA_X        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAMERA_Y        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPRITE_PALETTE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPRITE_PRIORITY = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHEET_BASE_TILE = 3'd4;

  localparam logic CMD_PLACE     = 1'b0;
  localparam logic CMD_NEW_FRAME = 1'b1;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic new_frame;
    logic step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic keep;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic       vflip;
    logic       hflip;
    logic       prio;
    logic [1:0] palette;
    logic [10:0] tile;
    logic [8:0] sy;
    logic [9:0] sx;
    logic [6:0] slot;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/mcsc_ctrl.sv @@
// Controller of the multi-cell sprite composer: request intake, cell scan and flush.
// Depends on mcsc_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module mcsc_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire                      req_cmd,
  input  wire mcsc_pkg::dp_stat_t  stat,
  output mcsc_pkg::dp_cmd_t        cmd
);

  mcsc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      mcsc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (req_cmd == mcsc_pkg::CMD_NEW_FRAME) begin
            cmd.new_frame = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = mcsc_pkg::ST_SCAN;
          end
        end
      end
      mcsc_pkg::ST_SCAN: begin
        // hold while the previous entry cannot leave
        if (!(stat.keep && stat.pend_valid && !stat.out_free)) begin
          cmd.step = 1'b1;
          if (stat.last_cell) begin
            state_nxt = mcsc_pkg::ST_FLUSH;
          end
        end
      end
      mcsc_pkg::ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = mcsc_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = mcsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mcsc_dp.sv @@
// Datapath of the multi-cell sprite composer: registers, cell counters, cull, slot count,
// one-entry lookahead and output register. Depends on mcsc_pkg; driven by mcsc_ctrl.
`default_nettype none

module mcsc_dp #(
  parameter int unsigned SHEET_ROW_CELLS    = 16,
  parameter int unsigned MAX_SLOTS          = 80,
  parameter int unsigned SCREEN_WIDTH       = 320,
  parameter int unsigned SCREEN_HEIGHT      = 224
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [mcsc_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire  [mcsc_pkg::CfgDataW-1:0]     cfg_wdata,
  input  wire  [10:0]                       req_cell_number,
  input  wire  [15:0]                       req_pos_x,
  input  wire  [15:0]                       req_pos_y,
  input  wire  [2:0]                        req_cells_wide,
  input  wire  [2:0]                        req_cells_high,
  input  wire  [1:0]                        req_flip_bits,
  input  wire mcsc_pkg::dp_cmd_t            cmd,
  output mcsc_pkg::dp_stat_t                stat,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output mcsc_pkg::entry_t                  out_entry,
  output logic                              out_last
);

  localparam int unsigned SlotW = $clog2(MAX_SLOTS + 1);
  localparam logic [SlotW-1:0]  MaxSlots    = SlotW'(MAX_SLOTS);
  localparam logic [10:0]       SheetAcross = 11'(SHEET_ROW_CELLS);
  localparam logic signed [17:0] ScreenW    = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] ScreenH    = 18'(SCREEN_HEIGHT);
  localparam logic signed [17:0] CullEdge   = -18'sd8;

  logic signed [15:0] camera_x_r;
  logic signed [15:0] camera_y_r;
  logic [1:0]         palette_r;
  logic               prio_r;
  logic [10:0]        base_tile_r;

  logic signed [16:0] bx_r, by_r;
  logic [10:0]        tile_base_r;
  logic [1:0]         wm1_r, hm1_r;
  logic               hf_r, vf_r;
  logic [1:0]         col_r, row_r;
  logic [SlotW-1:0]   slots_r;

  mcsc_pkg::entry_t   pend_r;
  logic               pend_valid_r;
  mcsc_pkg::entry_t   out_r;
  logic               out_last_r;
  logic               out_valid_r;

  logic [1:0]         wm1_nxt, hm1_nxt;
  logic signed [17:0] sx, sy;
  logic [1:0]         mcol, mrow;
  logic [10:0]        tile;
  logic               keep;
  logic               out_free;
  logic               push;
  mcsc_pkg::entry_t   entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_x_r  <= '0;
      camera_y_r  <= '0;
      palette_r   <= 2'd1;
      prio_r      <= 1'b1;
      base_tile_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcsc_pkg::CFG_CAMERA_X:        camera_x_r  <= cfg_wdata;
        mcsc_pkg::CFG_CAMERA_Y:        camera_y_r  <= cfg_wdata;
        mcsc_pkg::CFG_SPRITE_PALETTE:  palette_r   <= cfg_wdata[1:0];
        mcsc_pkg::CFG_SPRITE_PRIORITY: prio_r      <= cfg_wdata[0];
        mcsc_pkg::CFG_SHEET_BASE_TILE: base_tile_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // clamp size to 1..4, held as size minus one
  always_comb begin
    case (req_cells_wide)
      3'd0:    wm1_nxt = 2'd0;
      3'd1:    wm1_nxt = 2'd0;
      3'd2:    wm1_nxt = 2'd1;
      3'd3:    wm1_nxt = 2'd2;
      default: wm1_nxt = 2'd3;
    endcase
    case (req_cells_high)
      3'd0:    hm1_nxt = 2'd0;
      3'd1:    hm1_nxt = 2'd0;
      3'd2:    hm1_nxt = 2'd1;
      3'd3:    hm1_nxt = 2'd2;
      default: hm1_nxt = 2'd3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx_r        <= 17'(signed'(req_pos_x)) - 17'(camera_x_r);
      by_r        <= 17'(signed'(req_pos_y)) - 17'(camera_y_r);
      tile_base_r <= base_tile_r + req_cell_number;
      wm1_r       <= wm1_nxt;
      hm1_r       <= hm1_nxt;
      hf_r        <= req_flip_bits[0];
      vf_r        <= req_flip_bits[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.load) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.step) begin
      if (col_r == wm1_r) begin
        col_r <= '0;
        row_r <= row_r + 2'd1;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
  end

  always_comb begin
    sx    = 18'(bx_r) + 18'({col_r, 3'b000});
    sy    = 18'(by_r) + 18'({row_r, 3'b000});
    mcol  = hf_r ? (wm1_r - col_r) : col_r;
    mrow  = vf_r ? (hm1_r - row_r) : row_r;
    tile  = tile_base_r + 11'(mcol) + 11'(11'(mrow) * SheetAcross);
    keep  = (slots_r < MaxSlots) && (sx > CullEdge) && (sx < ScreenW)
            && (sy > CullEdge) && (sy < ScreenH);
    entry.slot    = 7'(slots_r);
    entry.sx      = sx[9:0];
    entry.sy      = sy[8:0];
    entry.tile    = tile;
    entry.palette = palette_r;
    entry.prio    = prio_r;
    entry.hflip   = hf_r;
    entry.vflip   = vf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= '0;
    end else if (cmd.new_frame) begin
      slots_r <= '0;
    end else if (cmd.step && keep) begin
      slots_r <= slots_r + SlotW'(1);
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign push     = (cmd.step && keep && pend_valid_r) || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.step && keep) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && keep) begin
      pend_r <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r      <= pend_r;
      out_last_r <= cmd.flush;
    end
  end

  assign stat.last_cell  = (col_r == wm1_r) && (row_r == hm1_r);
  assign stat.keep       = keep;
  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = out_free;

  assign out_tvalid = out_valid_r;
  assign out_entry  = out_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

@@ rtl/multi_cell_sprite_composer.sv @@
// Multi-cell sprite composer top level: stream ports, controller and datapath.
// Depends on mcsc_pkg, mcsc_ctrl and mcsc_dp.
//
// A place request (in_tuser 0) is split into up to 16 single-cell sprite entries, scanned
// row by row at one cell per cycle unless a kept cell waits for a full output; a request is
// loaded, its w*h cells are scanned, and a flush step ends it. Entries leave one entry
// behind through a one-entry lookahead so that the final one carries out_tlast. Cells
// wholly off screen or beyond MAX_SLOTS are dropped. A new-frame request (in_tuser 1)
// clears the slot count and gives no result. Configuration writes take effect at once.
`default_nettype none

module multi_cell_sprite_composer #(
  parameter int unsigned SHEET_ROW_CELLS    = 16,
  parameter int unsigned MAX_SLOTS          = 80,
  parameter int unsigned SCREEN_WIDTH       = 320,
  parameter int unsigned SCREEN_HEIGHT      = 224
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [mcsc_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire  [mcsc_pkg::CfgDataW-1:0]       cfg_wdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // cell_number[10:0] pos_x[26:11] pos_y[42:27] cells_wide[45:43] cells_high[48:46]
  // flip_bits[50:49], zeros above
  input  wire  [mcsc_pkg::InDataW-1:0]        in_tdata,
  // cmd[0]
  input  wire                                 in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // slot[6:0] screen_x[16:7] screen_y[25:17] tile_index[36:26] palette_line[38:37]
  // priority_res[39] hflip[40] vflip[41], zeros above
  output logic [mcsc_pkg::OutDataW-1:0]       out_tdata,
  output logic                                out_tlast
);

  mcsc_pkg::dp_cmd_t  dp_cmd;
  mcsc_pkg::dp_stat_t dp_stat;
  mcsc_pkg::entry_t   out_entry;

  mcsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_cmd   (in_tuser),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  mcsc_dp #(
    .SHEET_ROW_CELLS    (SHEET_ROW_CELLS),
    .MAX_SLOTS          (MAX_SLOTS),
    .SCREEN_WIDTH       (SCREEN_WIDTH),
    .SCREEN_HEIGHT      (SCREEN_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .req_cell_number (in_tdata[10:0]),
    .req_pos_x       (in_tdata[26:11]),
    .req_pos_y       (in_tdata[42:27]),
    .req_cells_wide  (in_tdata[45:43]),
    .req_cells_high  (in_tdata[48:46]),
    .req_flip_bits   (in_tdata[50:49]),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_entry       (out_entry),
    .out_last        (out_tlast)
  );

  assign out_tdata = {(mcsc_pkg::OutDataW - $bits(mcsc_pkg::entry_t))'(0), out_entry};

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[6:0]) < MAX_SLOTS))
    else $error("slot beyond MAX_SLOTS");

  a_place_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == mcsc_pkg::CMD_PLACE) |=> !in_tready)
    else $error("place request did not start a scan");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !dp_stat.pend_valid)
    else $error("pending entry left behind at idle");

  a_flush_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.flush |-> (dp_stat.pend_valid && dp_stat.out_free))
    else $error("flush without a pending entry or free output");

endmodule

`default_nettype wire
